>>> hdl/servo_bus_frame_deframer_assert.svh
// Assertion macros used by the frame deframer queue.
`ifndef SERVO_BUS_FRAME_DEFRAMER_ASSERT_SVH
`define SERVO_BUS_FRAME_DEFRAMER_ASSERT_SVH

// Property that must hold on every clock edge out of reset.
`define SBFD_CHECK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Antecedent in one cycle forces consequent in the next.
`define SBFD_CHECK_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/sbfd_pkg.sv
// Shared constants, types and helpers for the frame deframer.
`timescale 1ns / 1ps

package sbfd_pkg;

    localparam int MAX_PAYLOAD = 16;
    localparam logic [7:0] HDR_BYTE = 8'h55;
    localparam int IDX_W = 4;
    localparam int CNT_W = 5;
    localparam int QDEPTH = 2;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);
    localparam int MEM_DEPTH = QDEPTH * MAX_PAYLOAD;
    localparam int ADDR_W = $clog2(MEM_DEPTH);

    typedef struct packed {
        logic [7:0]       id;
        logic [7:0]       cmd;
        logic [CNT_W-1:0] kept;
        logic             trunc;
    } frame_desc_t;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [7:0]        wdata;
        logic              push;
        frame_desc_t       desc;
    } front_wr_t;

    typedef struct packed {
        logic              ren;
        logic [ADDR_W-1:0] raddr;
        logic              pop;
    } back_rd_t;

    function automatic logic [ADDR_W-1:0] bank_addr(input logic [QPTR_W-1:0] slot,
                                                    input logic [IDX_W-1:0]  idx);
        bank_addr = ADDR_W'(slot) * ADDR_W'(MAX_PAYLOAD) + ADDR_W'(idx);
    endfunction

endpackage

>>> hdl/sbfd_front.sv
// Byte parser: header hunt, field capture, checksum and frame hand-off.
`timescale 1ns / 1ps

module sbfd_front (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        accept,
    input  logic [7:0]                  rx_byte,
    input  logic                        end_of_chunk,
    input  logic [sbfd_pkg::QPTR_W-1:0] wr_slot,
    output sbfd_pkg::front_wr_t         wr
);
    import sbfd_pkg::*;

    localparam logic [2:0] PH_HUNT1 = 3'd0;
    localparam logic [2:0] PH_HUNT2 = 3'd1;
    localparam logic [2:0] PH_ID    = 3'd2;
    localparam logic [2:0] PH_LEN   = 3'd3;
    localparam logic [2:0] PH_CMD   = 3'd4;
    localparam logic [2:0] PH_DATA  = 3'd5;
    localparam logic [2:0] PH_CHECK = 3'd6;

    logic [2:0] phase_reg, phase_next;
    logic [7:0] id_reg, id_next;
    logic [7:0] len_reg, len_next;
    logic [7:0] cmd_reg, cmd_next;
    logic [7:0] seen_reg, seen_next;
    logic [7:0] sum_reg, sum_next;
    logic [7:0] total;
    logic       trunc;

    // length counts the command byte
    assign total = len_reg - 8'd1;
    assign trunc = total > 8'(MAX_PAYLOAD);

    always_comb
    begin
        phase_next = phase_reg;
        id_next    = id_reg;
        len_next   = len_reg;
        cmd_next   = cmd_reg;
        seen_next  = seen_reg;
        sum_next   = sum_reg;
        wr         = '0;
        wr.wdata   = rx_byte;
        wr.waddr   = bank_addr(wr_slot, seen_reg[IDX_W-1:0]);
        wr.desc.id    = id_reg;
        wr.desc.cmd   = cmd_reg;
        wr.desc.trunc = trunc;
        wr.desc.kept  = trunc ? CNT_W'(MAX_PAYLOAD) : total[CNT_W-1:0];
        if (accept)
        begin
            unique case (phase_reg)
                PH_HUNT1:
                begin
                    if (rx_byte == HDR_BYTE)
                    begin
                        phase_next = PH_HUNT2;
                    end
                end
                PH_HUNT2:
                begin
                    phase_next = (rx_byte == HDR_BYTE) ? PH_ID : PH_HUNT1;
                end
                PH_ID:
                begin
                    id_next    = rx_byte;
                    sum_next   = rx_byte;
                    phase_next = PH_LEN;
                end
                PH_LEN:
                begin
                    len_next   = rx_byte;
                    sum_next   = sum_reg + rx_byte;
                    phase_next = (rx_byte == 8'd0) ? PH_HUNT1 : PH_CMD;
                end
                PH_CMD:
                begin
                    cmd_next   = rx_byte;
                    sum_next   = sum_reg + rx_byte;
                    seen_next  = 8'd0;
                    phase_next = (len_reg == 8'd1) ? PH_CHECK : PH_DATA;
                end
                PH_DATA:
                begin
                    wr.we     = seen_reg < 8'(MAX_PAYLOAD);
                    sum_next  = sum_reg + rx_byte;
                    seen_next = seen_reg + 8'd1;
                    if ({1'b0, seen_reg} + 9'd2 >= {1'b0, len_reg})
                    begin
                        phase_next = PH_CHECK;
                    end
                end
                PH_CHECK:
                begin
                    wr.push    = (~sum_reg == rx_byte);
                    phase_next = PH_HUNT1;
                end
                default:
                begin
                    phase_next = PH_HUNT1;
                end
            endcase
            if (end_of_chunk)
            begin
                phase_next = PH_HUNT1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HUNT1;
            id_reg    <= '0;
            len_reg   <= '0;
            cmd_reg   <= '0;
            seen_reg  <= '0;
            sum_reg   <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            id_reg    <= id_next;
            len_reg   <= len_next;
            cmd_reg   <= cmd_next;
            seen_reg  <= seen_next;
            sum_reg   <= sum_next;
        end
    end

endmodule

>>> hdl/sbfd_queue.sv
// Two-slot frame queue with one payload bank per slot.
`timescale 1ns / 1ps
`include "servo_bus_frame_deframer_assert.svh"

module sbfd_queue (
    input  logic                        clk,
    input  logic                        rst_n,
    input  sbfd_pkg::front_wr_t         wr,
    input  sbfd_pkg::back_rd_t          rd,
    output logic                        full,
    output logic                        q_valid,
    output sbfd_pkg::frame_desc_t       head,
    output logic [sbfd_pkg::QPTR_W-1:0] wr_slot,
    output logic [sbfd_pkg::QPTR_W-1:0] rd_slot,
    output logic [7:0]                  rdata
);
    import sbfd_pkg::*;

    logic [7:0]        mem [MEM_DEPTH];
    frame_desc_t       desc_q [QDEPTH];
    logic [7:0]        rdata_reg;
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;

    // payload banks
    always_ff @(posedge clk)
    begin
        if (wr.we)
        begin
            mem[wr.waddr] <= wr.wdata;
        end
        if (rd.ren)
        begin
            rdata_reg <= mem[rd.raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr.push)
        begin
            desc_q[wr_ptr_reg] <= wr.desc;
        end
    end

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (wr.push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (rd.pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        priority if (wr.push && !rd.pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (rd.pop && !wr.push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    assign full    = (count_reg == QCNT_W'(QDEPTH));
    assign q_valid = (count_reg != '0);
    assign head    = desc_q[rd_ptr_reg];
    assign wr_slot = wr_ptr_reg;
    assign rd_slot = rd_ptr_reg;
    assign rdata   = rdata_reg;

    `SBFD_CHECK(a_count_bound, clk, rst_n, count_reg <= QCNT_W'(QDEPTH), "queue overfilled")
    `SBFD_CHECK(a_no_push_full, clk, rst_n, !(wr.push && full), "frame pushed while full")
    `SBFD_CHECK(a_no_pop_empty, clk, rst_n, !(rd.pop && !q_valid), "pop from empty queue")
    `SBFD_CHECK_NEXT(a_pop_moves, clk, rst_n, rd.pop && !wr.push, count_reg == $past(count_reg) - 1'b1, "pop lost")

endmodule

>>> hdl/sbfd_back.sv
// Result sequencer: walks the kept payload of the head frame, output register.
`timescale 1ns / 1ps

module sbfd_back (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        q_valid,
    input  sbfd_pkg::frame_desc_t       head,
    input  logic [sbfd_pkg::QPTR_W-1:0] rd_slot,
    input  logic [7:0]                  rdata,
    output sbfd_pkg::back_rd_t          rd,
    input  logic                        pop,
    output logic                        empty,
    output logic [7:0]                  servo_id,
    output logic [7:0]                  command,
    output logic [4:0]                  payload_count,
    output logic [3:0]                  byte_index,
    output logic [7:0]                  data_byte,
    output logic                        has_data,
    output logic                        truncated,
    output logic                        last
);
    import sbfd_pkg::*;

    logic [IDX_W-1:0] idx_reg, idx_next;
    logic             s1_valid_reg, s1_valid_next;
    logic             out_valid_reg, out_valid_next;
    frame_desc_t      s1_desc_reg, out_desc_reg;
    logic [IDX_W-1:0] s1_idx_reg, out_idx_reg;
    logic             s1_has_reg, out_has_reg;
    logic             s1_last_reg, out_last_reg;
    logic [7:0]       out_data_reg;
    logic             out_ready, s1_ready, issue, has, last_item, s1_move;

    assign out_ready = !out_valid_reg || pop;
    assign s1_ready  = !s1_valid_reg || out_ready;
    assign issue     = q_valid && s1_ready;
    assign s1_move   = s1_valid_reg && out_ready;
    assign has       = (head.kept != '0);
    assign last_item = !has || (CNT_W'(idx_reg) + 1'b1 == head.kept);

    always_comb
    begin
        rd.ren   = issue;
        rd.raddr = bank_addr(rd_slot, idx_reg);
        rd.pop   = issue && last_item;
        idx_next = idx_reg;
        if (issue)
        begin
            idx_next = last_item ? '0 : idx_reg + 1'b1;
        end
        s1_valid_next  = issue || (s1_valid_reg && !out_ready);
        out_valid_next = s1_move || (out_valid_reg && !pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg       <= idx_next;
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload path, no reset
    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            s1_desc_reg <= head;
            s1_idx_reg  <= has ? idx_reg : '0;
            s1_has_reg  <= has;
            s1_last_reg <= last_item;
        end
        if (s1_move)
        begin
            out_desc_reg <= s1_desc_reg;
            out_idx_reg  <= s1_idx_reg;
            out_has_reg  <= s1_has_reg;
            out_last_reg <= s1_last_reg;
            out_data_reg <= s1_has_reg ? rdata : 8'd0;
        end
    end

    assign empty         = !out_valid_reg;
    assign servo_id      = out_desc_reg.id;
    assign command       = out_desc_reg.cmd;
    assign payload_count = out_desc_reg.kept;
    assign byte_index    = out_idx_reg;
    assign data_byte     = out_data_reg;
    assign has_data      = out_has_reg;
    assign truncated     = out_desc_reg.trunc;
    assign last          = out_last_reg;

endmodule

>>> hdl/servo_bus_frame_deframer.sv
// Top level of the servo bus frame deframer.
`timescale 1ns / 1ps
//
//  channel  | direction | handshake                  | payload
//  ---------+-----------+----------------------------+------------------------------------
//  input    | in        | push / full                | rx_byte, end_of_chunk
//  result   | out       | empty / pop                | servo_id, command, payload_count,
//           |           |                            | byte_index, data_byte, has_data,
//           |           |                            | truncated, last
//
//  The parser takes one byte per cycle; a transaction on the input side
//  always completes in the cycle it is offered unless full is high.
//  A verified frame holds one of two queue slots (each with its own payload
//  bank) until the sequencer has issued its whole run of max(kept, 1) results,
//  one per cycle unless pop stalls, set by the single read port of the payload memory.
//  full rises only while two verified frames are waiting; result stalls on
//  pop back up through the read stage and output register into that queue.
//  Reset clears the parser, queue pointers and valid flags; no clearing pass.

module servo_bus_frame_deframer (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    output logic       full,
    input  logic [7:0] rx_byte,
    input  logic       end_of_chunk,
    output logic       empty,
    input  logic       pop,
    output logic [7:0] servo_id,
    output logic [7:0] command,
    output logic [4:0] payload_count,
    output logic [3:0] byte_index,
    output logic [7:0] data_byte,
    output logic       has_data,
    output logic       truncated,
    output logic       last
);
    import sbfd_pkg::*;

    front_wr_t         wr;
    back_rd_t          rd;
    frame_desc_t       head;
    logic [QPTR_W-1:0] wr_slot;
    logic [QPTR_W-1:0] rd_slot;
    logic [7:0]        rdata;
    logic              q_valid;
    logic              accept;

    // input transaction
    assign accept = push && !full;

    sbfd_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .rx_byte      (rx_byte),
        .end_of_chunk (end_of_chunk),
        .wr_slot      (wr_slot),
        .wr           (wr)
    );

    sbfd_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (wr),
        .rd      (rd),
        .full    (full),
        .q_valid (q_valid),
        .head    (head),
        .wr_slot (wr_slot),
        .rd_slot (rd_slot),
        .rdata   (rdata)
    );

    sbfd_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_valid       (q_valid),
        .head          (head),
        .rd_slot       (rd_slot),
        .rdata         (rdata),
        .rd            (rd),
        .pop           (pop),
        .empty         (empty),
        .servo_id      (servo_id),
        .command       (command),
        .payload_count (payload_count),
        .byte_index    (byte_index),
        .data_byte     (data_byte),
        .has_data      (has_data),
        .truncated     (truncated),
        .last          (last)
    );

endmodule

>>> bench/testbench.sv
// Self-checking bench for the servo bus frame deframer: directed table, random frames, scoreboard.
`timescale 1ns / 1ps

module testbench;

    import sbfd_pkg::*;

    localparam int HOLD_CYCLES  = 300;  // long receiver stall that must back the block up
    localparam int RANDOM_ITEMS = 280;
    localparam int N_DIR        = 28;

    // One result transaction, field for field as it leaves the block.
    typedef struct packed {
        logic [7:0] servo_id;
        logic [7:0] command;
        logic [4:0] count;
        logic [3:0] index;
        logic [7:0] data;
        logic       has_data;
        logic       truncated;
        logic       last;
    } deframed_t;

    // How a directed row gets its expectation.
    typedef enum logic [1:0] {
        BY_MODEL,    // whatever the predictor says
        TYPED_NONE,  // nothing may come out of this byte
        TYPED_ONE    // exactly the result typed in the row
    } row_check_t;

    typedef struct packed {
        logic [7:0] rx;
        logic       eoc;
        row_check_t how;
        deframed_t  want;
    } stim_row_t;

    // Parser phases of the predictor.
    typedef enum logic [2:0] {
        SYNC1,
        SYNC2,
        GET_ID,
        GET_LEN,
        GET_CMD,
        GET_DATA,
        GET_SUM
    } phase_t;

    localparam deframed_t NOTHING  = '0;
    // Empty payload frame with id and command at their top value.
    localparam deframed_t FF_EMPTY = '{8'hFF, 8'hFF, 5'd0, 4'd0, 8'h00, 1'b0, 1'b0, 1'b1};

    localparam stim_row_t DIRECTED [N_DIR] = '{
        // bad second header byte
        '{8'h55, 1'b0, TYPED_NONE, NOTHING},
        '{8'hAA, 1'b0, TYPED_NONE, NOTHING},
        // zero length, dropped on the length byte
        '{8'h55, 1'b0, TYPED_NONE, NOTHING},
        '{8'h55, 1'b0, TYPED_NONE, NOTHING},
        '{8'h12, 1'b0, TYPED_NONE, NOTHING},
        '{8'h00, 1'b0, TYPED_NONE, NOTHING},
        // empty payload, all ones, completing on a chunk end
        '{8'h55, 1'b0, TYPED_NONE, NOTHING},
        '{8'h55, 1'b0, TYPED_NONE, NOTHING},
        '{8'hFF, 1'b0, TYPED_NONE, NOTHING},
        '{8'h01, 1'b0, TYPED_NONE, NOTHING},
        '{8'hFF, 1'b0, TYPED_NONE, NOTHING},
        '{8'h00, 1'b1, TYPED_ONE,  FF_EMPTY},
        // bad checksum (FE would be right)
        '{8'h55, 1'b0, TYPED_NONE, NOTHING},
        '{8'h55, 1'b0, TYPED_NONE, NOTHING},
        '{8'h00, 1'b0, TYPED_NONE, NOTHING},
        '{8'h01, 1'b0, TYPED_NONE, NOTHING},
        '{8'h00, 1'b0, TYPED_NONE, NOTHING},
        '{8'h00, 1'b0, TYPED_NONE, NOTHING},
        // third 0x55 taken as the id, one payload byte
        '{8'h55, 1'b0, BY_MODEL,   NOTHING},
        '{8'h55, 1'b0, BY_MODEL,   NOTHING},
        '{8'h55, 1'b0, BY_MODEL,   NOTHING},
        '{8'h02, 1'b0, BY_MODEL,   NOTHING},
        '{8'h03, 1'b0, BY_MODEL,   NOTHING},
        '{8'hAB, 1'b0, BY_MODEL,   NOTHING},
        '{8'hFA, 1'b0, BY_MODEL,   NOTHING},
        // chunk end inside the frame abandons it
        '{8'h55, 1'b0, TYPED_NONE, NOTHING},
        '{8'h55, 1'b0, TYPED_NONE, NOTHING},
        '{8'h07, 1'b1, TYPED_NONE, NOTHING}
    };

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       push = 1'b0;
    logic       full;
    logic [7:0] rx_byte = 8'h00;
    logic       end_of_chunk = 1'b0;
    logic       empty;
    logic       pop = 1'b0;
    logic [7:0] servo_id;
    logic [7:0] command;
    logic [4:0] payload_count;
    logic [3:0] byte_index;
    logic [7:0] data_byte;
    logic       has_data;
    logic       truncated;
    logic       last;

    servo_bus_frame_deframer dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .full          (full),
        .rx_byte       (rx_byte),
        .end_of_chunk  (end_of_chunk),
        .empty         (empty),
        .pop           (pop),
        .servo_id      (servo_id),
        .command       (command),
        .payload_count (payload_count),
        .byte_index    (byte_index),
        .data_byte     (data_byte),
        .has_data      (has_data),
        .truncated     (truncated),
        .last          (last)
    );

    always #5 clk = ~clk;

    // Predictor state.
    phase_t     ph;
    logic [7:0] f_id;
    logic [7:0] f_len;
    logic [7:0] f_cmd;
    logic [7:0] f_seen;
    logic [7:0] f_sum;
    logic [7:0] f_store [MAX_PAYLOAD];

    deframed_t  just_made [$];
    deframed_t  expected_results [$];

    int errors       = 0;
    int n_items      = 0;
    int n_rnd_items  = 0;
    int n_frames     = 0;
    int n_trunc      = 0;
    int n_checked    = 0;
    bit calm         = 1'b0;  // no idling on either side
    bit hold_req     = 1'b0;

    // Parse one byte; any frame it completes is appended to just_made.
    task automatic parse_rx_byte(input logic [7:0] b, input logic eoc);
        int        total;
        int        kept;
        int        runs;
        deframed_t r;
        case (ph)
            SYNC1:   if (b == HDR_BYTE) ph = SYNC2;
            SYNC2:   ph = (b == HDR_BYTE) ? GET_ID : SYNC1;
            GET_ID:
            begin
                f_id  = b;
                f_sum = b;
                ph    = GET_LEN;
            end
            GET_LEN:
            begin
                f_len = b;
                f_sum = f_sum + b;
                ph    = (b == 8'd0) ? SYNC1 : GET_CMD;
            end
            GET_CMD:
            begin
                f_cmd  = b;
                f_sum  = f_sum + b;
                f_seen = 8'd0;
                ph     = (f_len == 8'd1) ? GET_SUM : GET_DATA;
            end
            GET_DATA:
            begin
                if (int'(f_seen) < MAX_PAYLOAD) f_store[f_seen[3:0]] = b;
                f_sum  = f_sum + b;
                f_seen = f_seen + 8'd1;
                if (int'(f_seen) + 1 >= int'(f_len)) ph = GET_SUM;
            end
            GET_SUM:
            begin
                if (~f_sum == b)
                begin
                    total = int'(f_len) - 1;
                    kept  = (total > MAX_PAYLOAD) ? MAX_PAYLOAD : total;
                    runs  = (kept == 0) ? 1 : kept;
                    n_frames++;
                    if (total > MAX_PAYLOAD) n_trunc++;
                    for (int k = 0; k < runs; k++)
                    begin
                        r.servo_id  = f_id;
                        r.command   = f_cmd;
                        r.count     = CNT_W'(kept);
                        r.index     = (kept == 0) ? 4'd0 : IDX_W'(k);
                        r.data      = (kept == 0) ? 8'h00 : f_store[IDX_W'(k)];
                        r.has_data  = (kept != 0);
                        r.truncated = (total > MAX_PAYLOAD);
                        r.last      = (k + 1 == runs);
                        just_made.push_back(r);
                    end
                end
                ph = SYNC1;
            end
            default: ph = SYNC1;
        endcase
        if (eoc) ph = SYNC1;
    endtask

    // Offer one byte from a falling edge, hold it until taken, predict, and
    // return at the next falling edge with push still high.
    task automatic send_item(input logic [7:0] b, input logic eoc,
                             input row_check_t how, input deframed_t want);
        push         <= 1'b1;
        rx_byte      <= b;
        end_of_chunk <= eoc;
        do @(posedge clk); while (full !== 1'b0);
        just_made.delete();
        parse_rx_byte(b, eoc);
        case (how)
            BY_MODEL:  foreach (just_made[i]) expected_results.push_back(just_made[i]);
            TYPED_ONE: expected_results.push_back(want);
            default:   ;
        endcase
        n_items++;
        @(negedge clk);
    endtask

    task automatic sender_gap();
        if (!calm && $urandom_range(0, 7) == 0)
        begin
            push <= 1'b0;
            repeat ($urandom_range(1, 15)) @(negedge clk);
        end
    endtask

    task automatic offer(input logic [7:0] b, input logic eoc);
        sender_gap();
        send_item(b, eoc, BY_MODEL, NOTHING);
        n_rnd_items++;
    endtask

    // One random chunk of traffic: mostly well formed frames with random
    // content, some corrupt or abandoned, some plain noise.
    task automatic send_random_frame();
        int         r;
        int         len;
        int         pos;
        int         cut_at;
        logic [7:0] id;
        logic [7:0] cmd;
        logic [7:0] sum;
        logic [7:0] pb;
        logic [7:0] cs;
        r = $urandom_range(0, 99);
        if (r < 6)
        begin
            repeat ($urandom_range(1, 4))
                offer(8'($urandom_range(0, 255)), $urandom_range(0, 9) == 0);
            return;
        end
        if (r < 10)
        begin
            pb = 8'($urandom_range(0, 254));
            if (pb >= HDR_BYTE) pb = pb + 8'd1;
            offer(HDR_BYTE, 1'b0);
            offer(pb, 1'b0);
            return;
        end
        r = $urandom_range(0, 99);
        if (r < 45)      len = $urandom_range(1, 5);
        else if (r < 75) len = $urandom_range(6, MAX_PAYLOAD + 1);
        else if (r < 93) len = $urandom_range(MAX_PAYLOAD + 2, 40);
        else if (r < 98) len = $urandom_range(41, 255);
        else             len = 0;
        id  = ($urandom_range(0, 9) == 0) ? HDR_BYTE : 8'($urandom_range(0, 255));
        cmd = 8'($urandom_range(0, 255));
        // byte positions run 0 .. len+4, the last one being the checksum
        cut_at = -1;
        if ($urandom_range(0, 19) == 0)      cut_at = $urandom_range(0, len + 4);
        else if ($urandom_range(0, 11) == 0) cut_at = len + 4;
        pos = 0;
        offer(HDR_BYTE, pos == cut_at); pos++;
        offer(HDR_BYTE, pos == cut_at); pos++;
        offer(id, pos == cut_at);       pos++;
        offer(8'(len), pos == cut_at);  pos++;
        if (len == 0) return;
        offer(cmd, pos == cut_at);      pos++;
        sum = id + 8'(len) + cmd;
        for (int i = 0; i < len - 1; i++)
        begin
            pb  = 8'($urandom_range(0, 255));
            sum = sum + pb;
            offer(pb, pos == cut_at);
            pos++;
        end
        cs = ~sum;
        if ($urandom_range(0, 9) == 0) cs = cs ^ 8'($urandom_range(1, 255));
        offer(cs, pos == cut_at);
    endtask

    function automatic void check_field(input string name, input logic [7:0] want,
                                        input logic [7:0] got);
        if (got !== want)
        begin
            $error("%s: expected %h, got %h", name, want, got);
            errors++;
        end
    endfunction

    // Scoreboard: every popped result against the oldest expectation.
    always @(posedge clk)
    begin : scoreboard
        deframed_t want;
        if (rst_n && pop && empty === 1'b0)
        begin
            if (expected_results.size() == 0)
            begin
                $error("unexpected result: id %h command %h index %0d data %h",
                       servo_id, command, byte_index, data_byte);
                errors++;
            end
            else
            begin
                want = expected_results.pop_front();
                check_field("servo_id",      want.servo_id,       servo_id);
                check_field("command",       want.command,        command);
                check_field("payload_count", 8'(want.count),      8'(payload_count));
                check_field("byte_index",    8'(want.index),      8'(byte_index));
                check_field("data_byte",     want.data,           data_byte);
                check_field("has_data",      8'(want.has_data),   8'(has_data));
                check_field("truncated",     8'(want.truncated),  8'(truncated));
                check_field("last",          8'(want.last),       8'(last));
                n_checked++;
            end
        end
    end

    // Receiver: random stall bursts, one long hold-off on request.
    initial
    begin : receiver
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                pop <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge clk);
            end
            else if (!calm && $urandom_range(0, 9) == 0)
            begin
                pop <= 1'b0;
                repeat ($urandom_range(1, 15) - 1) @(negedge clk);
            end
            else
            begin
                pop <= 1'b1;
            end
        end
    end

    // Watchdog.
    initial
    begin : watchdog
        #5_000_000;
        $display("FAIL");
        $finish;
    end

    initial
    begin : stimulus
        bit held;
        bit paused;
        held   = 1'b0;
        paused = 1'b0;
        ph     = SYNC1;
        f_id   = '0;
        f_len  = '0;
        f_cmd  = '0;
        f_seen = '0;
        f_sum  = '0;
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (DIRECTED[i])
        begin
            sender_gap();
            send_item(DIRECTED[i].rx, DIRECTED[i].eoc, DIRECTED[i].how, DIRECTED[i].want);
        end

        while (n_rnd_items < RANDOM_ITEMS)
        begin
            if (!held && n_rnd_items >= 80)
            begin
                // receiver stalls while we keep feeding frames in
                held     = 1'b1;
                hold_req = 1'b1;
            end
            if (!paused && n_rnd_items >= 180)
            begin
                // let the block drain completely before going on
                paused = 1'b1;
                push <= 1'b0;
                wait (expected_results.size() == 0);
                @(negedge clk);
            end
            if (n_rnd_items >= RANDOM_ITEMS - 40) calm = 1'b1;
            send_random_frame();
        end
        push <= 1'b0;

        wait (expected_results.size() == 0);
        repeat (20) @(posedge clk);
        $display("Sent %0d bytes; %0d frames passed their checksum, %0d of them truncated.",
                 n_items, n_frames, n_trunc);
        $display("Checked %0d result transactions against the predictor.", n_checked);
        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

>>> sim.f
+incdir+hdl
hdl/sbfd_pkg.sv
hdl/sbfd_front.sv
hdl/sbfd_queue.sv
hdl/sbfd_back.sv
hdl/servo_bus_frame_deframer.sv
bench/testbench.sv
